FILE: rtl/core/swa_pkg.sv
// Shared types and constants for the sliding window aggregate core.
// No dependencies; swa_front, swa_div, swa_back and the top level import this package.
package swa_pkg;

    // Sizes of the window ring and the sample path.
    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int ADDR_BITS    = $clog2(WINDOW_MAX);
    localparam int CNT_BITS     = $clog2(WINDOW_MAX + 1);
    localparam int AGG_BITS     = SAMPLE_BITS + ADDR_BITS;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = CNT_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WLEN = CFG_IDX_BITS'(1);

    // Window length after reset.
    localparam logic [CNT_BITS-1:0] WLEN_RESET = CNT_BITS'(8);

    // Aggregate kinds.
    typedef enum logic [1:0] {
        MODE_AVG = 2'd0,
        MODE_MIN = 2'd1,
        MODE_MAX = 2'd2,
        MODE_SUM = 2'd3
    } t_swa_mode;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_WALK,
        ST_DIV
    } t_swa_state;

    // Status of the back end, watched by the top level.
    typedef struct packed {
        logic                take;
        logic [CNT_BITS-1:0] fill;
    } t_swa_status;

endpackage

FILE: rtl/core/swa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/swa_front.sv
// Front end: accepts sample words and holds them in a short queue for the back end.
// Depends on swa_pkg.
module swa_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [swa_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                           o_in_stall,
    output logic                           o_q_valid,
    output logic [swa_pkg::SAMPLE_BITS-1:0] o_q_sample,
    input  logic                           i_q_take
);
    import swa_pkg::*;

    logic [SAMPLE_BITS-1:0] r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wp, n_wp;
    logic [QPTR_BITS-1:0]   r_rp, n_rp;
    logic [QCNT_BITS-1:0]   r_cnt, n_cnt;
    logic                   push;
    logic                   pop;
    logic                   full;

    // Queue occupancy and handshakes.
    assign full       = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_in_stall = full;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_sample = r_q[r_rp];
    assign push       = i_in_valid && !full;
    assign pop        = i_q_take && o_q_valid;

    // Pointer and count updates.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_BITS'(1);
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_BITS'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_BITS'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_sample;
        end
    end

endmodule

FILE: rtl/core/swa_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on swa_pkg.
module swa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swa_pkg::AGG_BITS-1:0]  i_dividend,
    input  logic [swa_pkg::CNT_BITS-1:0]  i_divisor,
    output logic                          o_done,
    output logic [swa_pkg::AGG_BITS-1:0]  o_quotient
);
    import swa_pkg::*;

    localparam int STEP_BITS = $clog2(AGG_BITS + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [STEP_BITS-1:0]  r_step, n_step;
    logic [AGG_BITS-1:0]   r_quot, n_quot;
    logic [CNT_BITS-1:0]   r_rem, n_rem;
    logic [CNT_BITS-1:0]   r_divisor, n_divisor;
    logic [CNT_BITS:0]     rem_sh;
    logic [CNT_BITS:0]     diff;
    logic                  ge;

    // One shift-and-subtract step.
    assign rem_sh = {r_rem, r_quot[AGG_BITS-1]};
    assign diff   = rem_sh - {1'b0, r_divisor};
    assign ge     = (rem_sh >= {1'b0, r_divisor});

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_step    = r_step;
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        if (i_start) begin
            n_busy    = 1'b1;
            n_step    = '0;
            n_quot    = i_dividend;
            n_rem     = '0;
            n_divisor = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[AGG_BITS-2:0], ge};
            n_rem  = ge ? diff[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
            n_step = r_step + STEP_BITS'(1);
            if (r_step == STEP_BITS'(AGG_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

FILE: rtl/core/swa_back.sv
// Back end: emits the held aggregate, inserts the sample into the ring and
// recomputes the aggregate by walking the ring. Depends on swa_pkg, swa_ram, swa_div.
module swa_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swa_pkg::t_swa_mode              i_mode,
    input  logic [swa_pkg::CNT_BITS-1:0]    i_window_len,
    input  logic                            i_q_valid,
    input  logic [swa_pkg::SAMPLE_BITS-1:0] i_q_sample,
    output logic                            o_q_take,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [swa_pkg::AGG_BITS-1:0]    o_aggregate,
    output logic [swa_pkg::CNT_BITS-1:0]    o_prior_count,
    output swa_pkg::t_swa_status            o_status
);
    import swa_pkg::*;

    t_swa_state             r_state, n_state;
    logic [ADDR_BITS-1:0]   r_slot, n_slot;
    logic [CNT_BITS-1:0]    r_fill, n_fill;
    logic [AGG_BITS-1:0]    r_held, n_held;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [CNT_BITS-1:0]    r_issue, n_issue;
    logic                   r_pend, n_pend;
    logic [AGG_BITS-1:0]    r_sum, n_sum;
    logic [SAMPLE_BITS-1:0] r_lo, n_lo;
    logic [SAMPLE_BITS-1:0] r_hi, n_hi;
    logic                   r_first, n_first;
    logic                   r_out_valid, n_out_valid;
    logic [AGG_BITS-1:0]    r_out_agg, n_out_agg;
    logic [CNT_BITS-1:0]    r_out_cnt, n_out_cnt;

    logic [CNT_BITS-1:0]    eff_len;
    logic [CNT_BITS-1:0]    fill_c;
    logic [ADDR_BITS-1:0]   slot_c;
    logic [CNT_BITS-1:0]    slot_inc;
    logic                   out_free;
    logic                   take;
    logic                   walk_done;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   div_start;
    logic                   div_done;
    logic [AGG_BITS-1:0]    div_quot;

    // Effective window length: zero counts as one, larger than the ring clamps.
    always_comb begin
        if (i_window_len == '0) begin
            eff_len = CNT_BITS'(1);
        end else if (i_window_len > CNT_BITS'(WINDOW_MAX)) begin
            eff_len = CNT_BITS'(WINDOW_MAX);
        end else begin
            eff_len = i_window_len;
        end
    end

    // Fill count and write slot after a possible window shrink.
    assign fill_c    = (r_fill > eff_len) ? eff_len : r_fill;
    assign slot_c    = (CNT_BITS'(r_slot) >= eff_len) ? '0 : r_slot;
    assign slot_inc  = CNT_BITS'(slot_c) + CNT_BITS'(1);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign walk_done = (r_issue == r_fill) && !r_pend;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = (i_mode == MODE_AVG) ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        take      = (r_state == ST_IDLE) && i_q_valid && out_free;
        ram_we    = (r_state == ST_INSERT);
        ram_raddr = r_issue[ADDR_BITS-1:0];
        div_start = (r_state == ST_WALK) && walk_done && (i_mode == MODE_AVG);
    end

    // Datapath next values.
    always_comb begin
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_held      = r_held;
        n_sample    = r_sample;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_sum       = r_sum;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_first     = r_first;
        n_out_valid = r_out_valid;
        n_out_agg   = r_out_agg;
        n_out_cnt   = r_out_cnt;

        // Output word: the aggregate held from the previous sample.
        if (take) begin
            n_out_valid = 1'b1;
            n_out_agg   = r_held;
            n_out_cnt   = r_fill;
            n_sample    = i_q_sample;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_INSERT: begin
                n_fill  = (fill_c < eff_len) ? fill_c + CNT_BITS'(1) : fill_c;
                n_slot  = (slot_inc >= eff_len) ? '0 : slot_inc[ADDR_BITS-1:0];
                n_issue = '0;
                n_pend  = 1'b0;
                n_sum   = '0;
                n_first = 1'b1;
            end
            ST_WALK: begin
                // Issue one read per cycle and fold in each word in the cycle after its read is issued.
                n_pend = (r_issue < r_fill);
                if (r_issue < r_fill) begin
                    n_issue = r_issue + CNT_BITS'(1);
                end
                if (r_pend) begin
                    n_sum   = r_sum + AGG_BITS'(ram_rdata);
                    n_first = 1'b0;
                    if (r_first || ram_rdata < r_lo) begin
                        n_lo = ram_rdata;
                    end
                    if (r_first || ram_rdata > r_hi) begin
                        n_hi = ram_rdata;
                    end
                end
                if (walk_done) begin
                    case (i_mode)
                        MODE_MIN: n_held = AGG_BITS'(r_lo);
                        MODE_MAX: n_held = AGG_BITS'(r_hi);
                        MODE_SUM: n_held = r_sum;
                        default:  n_held = r_held;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_held = div_quot;
                end
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_held      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_held      <= n_held;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_issue   <= n_issue;
        r_sum     <= n_sum;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_first   <= n_first;
        r_out_agg <= n_out_agg;
        r_out_cnt <= n_out_cnt;
    end

    // Window ring.
    swa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_c),
        .i_wdata (r_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Serial divider for the average.
    swa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign o_q_take      = take;
    assign o_out_valid   = r_out_valid;
    assign o_aggregate   = r_out_agg;
    assign o_prior_count = r_out_cnt;
    assign o_status.take = take;
    assign o_status.fill = r_fill;

endmodule

FILE: rtl/core/sliding_window_aggregate_core.sv
// Top level of the sliding window aggregate core: configuration registers,
// front queue and back end. Depends on swa_pkg, swa_front, swa_back.
//
//   Channel   Direction  Handshake                 Word
//   input     in         i_in_valid / o_in_stall   i_sample
//   output    out        o_out_valid / i_out_stall o_aggregate, o_prior_count
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// An item walks all samples in the window (fill, up to 64) in minimum, maximum and sum
// mode, and walks them and then divides in average mode; no new sample is taken until then.
// The time is set by the walk over the single read port of the window ring and
// by the one-bit-per-cycle divider. Reset clears the window count, write slot and
// held aggregate, sets mode to average and window length to 8; the ring itself is
// not cleared. A stalled output word holds while the next sample waits in the queue.
module sliding_window_aggregate_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [swa_pkg::SAMPLE_BITS-1:0]   i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [swa_pkg::AGG_BITS-1:0]      o_aggregate,
    output logic [swa_pkg::CNT_BITS-1:0]      o_prior_count,
    input  logic                              i_cfg_we,
    input  logic [swa_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [swa_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import swa_pkg::*;

    t_swa_mode              r_mode, n_mode;
    logic [CNT_BITS-1:0]    r_wlen, n_wlen;
    logic                   q_valid;
    logic [SAMPLE_BITS-1:0] q_sample;
    logic                   q_take;
    t_swa_status            status;

    // Configuration register writes.
    always_comb begin
        n_mode = r_mode;
        n_wlen = r_wlen;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE: n_mode = t_swa_mode'(i_cfg_data[1:0]);
                CFG_WLEN: n_wlen = i_cfg_data[CNT_BITS-1:0];
                default:  n_mode = r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_AVG;
            r_wlen <= WLEN_RESET;
        end else begin
            r_mode <= n_mode;
            r_wlen <= n_wlen;
        end
    end

    // Front end and queue.
    swa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sample   (i_sample),
        .o_in_stall (o_in_stall),
        .o_q_valid  (q_valid),
        .o_q_sample (q_sample),
        .i_q_take   (q_take)
    );

    // Back end.
    swa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_mode),
        .i_window_len  (r_wlen),
        .i_q_valid     (q_valid),
        .i_q_sample    (q_sample),
        .o_q_take      (q_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_aggregate   (o_aggregate),
        .o_prior_count (o_prior_count),
        .o_status      (status)
    );

`ifndef SYNTHESIS
    // The window count never exceeds the ring size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.fill <= CNT_BITS'(WINDOW_MAX))
        else $error("window count beyond ring size");

    // A new output word appears only when the back end takes a sample.
    a_out_from_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(status.take))
        else $error("output word without a taken sample");

    // After a sample is inserted the window is never empty.
    a_fill_after_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.take |=> ##1 (status.fill != '0))
        else $error("empty window after insert");
`endif

endmodule
